// ----- rtl/pfdm_pkg.sv -----
// Shared types, field widths and constants of the pulse frequency and duty meter.
`default_nettype none

package pfdm_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int FREQ_W     = 23;
  localparam int DUTY_W     = 14;
  localparam int MEAN_W     = 12;
  localparam int TMO_W      = 14;
  localparam int SUM_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 64;
  localparam int M_TUSER_W  = 2;
  localparam int NUMER_W    = 24;

  localparam logic [NUMER_W-1:0] FREQ_NUMERATOR = 24'd10000000;
  localparam logic [DUTY_W-1:0]  DUTY_SCALE     = 14'd10000;
  localparam logic [MEAN_W-1:0]  MEAN_MAX       = 12'd4095;

  localparam logic [1:0] LVL_UNKNOWN = 2'd0;
  localparam logic [1:0] LVL_LOW     = 2'd1;
  localparam logic [1:0] LVL_HIGH    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd4;

  localparam logic [SAMPLE_W-1:0] RST_HIGH_THR = 12'd2500;
  localparam logic [SAMPLE_W-1:0] RST_LOW_THR  = 12'd1500;
  localparam logic [FREQ_W-1:0]   RST_MAX_FREQ = 23'd100000;
  localparam logic [FREQ_W-1:0]   RST_MIN_FREQ = 23'd100;
  localparam logic [TMO_W-1:0]    RST_TIMEOUT  = 14'd5000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] high_thr;
    logic [SAMPLE_W-1:0] low_thr;
    logic [FREQ_W-1:0]   max_freq;
    logic [FREQ_W-1:0]   min_freq;
    logic [TMO_W-1:0]    timeout;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- rtl/pulse_frequency_duty_meter_unit.sv -----
// Top level of the pulse frequency and duty meter: level sorting, accumulators, sequencer.
`default_nettype none

// Takes one 12-bit ADC sample per input item and returns one result item per sample.
// Samples are sorted into high or low level against two thresholds, counted and summed;
// on a low-to-high change the period just ended is measured (frequency in centihertz,
// duty in 1/10000, mean high and low codes) and the accumulators restart. On a rising
// edge the four results come one after another out of a single restoring divider,
// DW = max(32, COUNT_BITS + 14) bits wide, that yields one quotient bit per cycle. The
// input is not ready while an item is in work; a finished result waits in the output
// register while the next sample is taken.
module pulse_frequency_duty_meter_unit
  import pfdm_pkg::*;
#(
  parameter int COUNT_BITS = 20,
  parameter int TIMER_BITS = 14
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [11:0] sample
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [22:0] freq_centihz, [36:23] duty_permyriad, [48:37] high_mean, [60:49] low_mean
  output logic      [M_TDATA_W-1:0]  m_axis_tdata_o,
  // [0] new_period, [1] timed_out
  output logic      [M_TUSER_W-1:0]  m_axis_tuser_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DW     = (COUNT_BITS + DUTY_W > SUM_W) ? COUNT_BITS + DUTY_W : SUM_W;
  localparam int VW     = COUNT_BITS + 1;
  localparam int PROD_W = COUNT_BITS + DUTY_W;
  localparam int TW     = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;
  localparam int PAD_W  = M_TDATA_W - FREQ_W - DUTY_W - 2 * MEAN_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FREQ  = 3'd1;
  localparam logic [2:0] S_DUTY  = 3'd2;
  localparam logic [2:0] S_HMEAN = 3'd3;
  localparam logic [2:0] S_LMEAN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  cfg_t      cfg;
  div_stat_t div_stat;

  logic [2:0]            state_q, state_d;
  logic [1:0]            last_q;
  logic [COUNT_BITS-1:0] hc_q, lc_q;
  logic [SUM_W-1:0]      hs_q, ls_q;
  logic [TIMER_BITS-1:0] since_q;
  logic [FREQ_W-1:0]     freq_q;
  logic [DUTY_W-1:0]     duty_q;
  logic [MEAN_W-1:0]     hmean_q, lmean_q;
  logic                  fok_q, rise_q, tout_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  m_tvalid_q;
  logic [M_TDATA_W-1:0]  m_tdata_q;
  logic [M_TUSER_W-1:0]  m_tuser_q;

  logic [SAMPLE_W-1:0]   sample;
  logic                  is_high, is_low, rise, tout, accept, load_out;
  logic [COUNT_BITS-1:0] hc_inc, lc_inc;
  logic [SUM_W:0]        hs_add, ls_add;
  logic [VW-1:0]         n_sum;
  logic                  div_start;
  logic [DW-1:0]         div_dividend, quo;
  logic [VW-1:0]         div_divisor;
  logic [MEAN_W-1:0]     mean_clamped;

  pfdm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pfdm_div #(
    .DIVIDEND_W (DW),
    .DIVISOR_W  (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quo),
    .stat_o     (div_stat)
  );

  assign sample   = s_axis_tdata_i[SAMPLE_W-1:0];
  // High test first: a sample passing both thresholds is high.
  assign is_high  = sample > cfg.high_thr;
  assign is_low   = !is_high && (sample < cfg.low_thr);
  assign rise     = (last_q == LVL_LOW) && is_high;
  // A rising edge suppresses the timeout test and restarts the edge timer at one.
  assign tout     = !rise && (TW'(since_q) > TW'(cfg.timeout));
  assign hc_inc   = (hc_q != '1) ? hc_q + 1'b1 : hc_q;
  assign lc_inc   = (lc_q != '1) ? lc_q + 1'b1 : lc_q;
  assign hs_add   = {1'b0, hs_q} + (SUM_W + 1)'(sample);
  assign ls_add   = {1'b0, ls_q} + (SUM_W + 1)'(sample);
  assign n_sum    = {1'b0, hc_q} + {1'b0, lc_q};

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign load_out        = (state_q == S_DONE) && (!m_tvalid_q || m_axis_tready_i);

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  assign mean_clamped = (|quo[DW-1:MEAN_W]) ? MEAN_MAX : quo[MEAN_W-1:0];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = n_sum;
    case (state_q)
      S_FREQ: begin
        div_start    = !div_stat.busy && !div_stat.done;
        div_dividend = DW'(FREQ_NUMERATOR);
      end
      S_DUTY: begin
        div_start    = !div_stat.busy && !div_stat.done;
        div_dividend = DW'(prod_q);
      end
      S_HMEAN: begin
        div_start    = !div_stat.busy && !div_stat.done;
        div_dividend = DW'(hs_q);
        div_divisor  = VW'(hc_q);
      end
      S_LMEAN: begin
        div_start    = !div_stat.busy && !div_stat.done;
        div_dividend = DW'(ls_q);
        div_divisor  = VW'(lc_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) begin
        state_d = rise ? S_FREQ : S_DONE;
      end
      S_FREQ:  if (div_stat.done) begin
        state_d = S_DUTY;
      end
      S_DUTY:  if (div_stat.done) begin
        state_d = S_HMEAN;
      end
      S_HMEAN: if (div_stat.done) begin
        state_d = S_LMEAN;
      end
      S_LMEAN: if (div_stat.done) begin
        state_d = S_DONE;
      end
      S_DONE:  if (load_out) begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      last_q     <= LVL_UNKNOWN;
      hc_q       <= '0;
      lc_q       <= '0;
      hs_q       <= '0;
      ls_q       <= '0;
      since_q    <= '0;
      freq_q     <= '0;
      duty_q     <= '0;
      hmean_q    <= '0;
      lmean_q    <= '0;
      fok_q      <= 1'b0;
      rise_q     <= 1'b0;
      tout_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (is_high) begin
          hc_q   <= hc_inc;
          hs_q   <= hs_add[SUM_W] ? '1 : hs_add[SUM_W-1:0];
          last_q <= LVL_HIGH;
        end else if (is_low) begin
          lc_q   <= lc_inc;
          ls_q   <= ls_add[SUM_W] ? '1 : ls_add[SUM_W-1:0];
          last_q <= LVL_LOW;
        end
        if (rise) begin
          since_q <= TIMER_BITS'(1);
        end else if (since_q != '1) begin
          since_q <= since_q + 1'b1;
        end
        rise_q <= rise;
        tout_q <= tout;
        if (tout) begin
          freq_q  <= '0;
          duty_q  <= '0;
          hmean_q <= '0;
          lmean_q <= '0;
        end
      end
      if (div_stat.done) begin
        case (state_q)
          S_FREQ: begin
            freq_q <= quo[FREQ_W-1:0];
            fok_q  <= (quo <= DW'(cfg.max_freq)) && (quo >= DW'(cfg.min_freq));
          end
          S_DUTY:  duty_q  <= quo[DUTY_W-1:0];
          S_HMEAN: hmean_q <= mean_clamped;
          S_LMEAN: begin
            lmean_q <= (!fok_q || lc_q == '0) ? '0 : mean_clamped;
            // Frequency out of limits: drop the whole measurement.
            if (!fok_q) begin
              freq_q  <= '0;
              duty_q  <= '0;
              hmean_q <= '0;
            end
            hc_q <= '0;
            lc_q <= '0;
            hs_q <= '0;
            ls_q <= '0;
          end
          default: ;
        endcase
      end
      if (load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(hc_q) * PROD_W'(DUTY_SCALE);
    if (load_out) begin
      m_tdata_q <= {PAD_W'(0), lmean_q, hmean_q, duty_q, freq_q};
      m_tuser_q <= {tout_q, rise_q};
    end
  end

`ifndef SYNTHESIS
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_stat.busy)
    else $error("input ready while divider busy");
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("rising edge and timeout flagged together");
  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (m_axis_tdata_o == '0))
    else $error("timeout item carries nonzero results");
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[36:23] <= DUTY_SCALE))
    else $error("duty above full scale");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> $past(div_stat.busy))
    else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

// ----- rtl/pfdm_cfg.sv -----
// Configuration register file of the meter, written through a valid/ready port.
`default_nettype none

module pfdm_cfg
  import pfdm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr <= RST_HIGH_THR;
      cfg_q.low_thr  <= RST_LOW_THR;
      cfg_q.max_freq <= RST_MAX_FREQ;
      cfg_q.min_freq <= RST_MIN_FREQ;
      cfg_q.timeout  <= RST_TIMEOUT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HIGH_THR: cfg_q.high_thr <= cfg_data_i[SAMPLE_W-1:0];
        REG_LOW_THR:  cfg_q.low_thr  <= cfg_data_i[SAMPLE_W-1:0];
        REG_MAX_FREQ: cfg_q.max_freq <= cfg_data_i[FREQ_W-1:0];
        REG_MIN_FREQ: cfg_q.min_freq <= cfg_data_i[FREQ_W-1:0];
        REG_TIMEOUT:  cfg_q.timeout  <= cfg_data_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pfdm_div.sv -----
// Shared restoring divider: one quotient bit per clock cycle.
`default_nettype none

module pfdm_div
  import pfdm_pkg::*;
#(
  parameter int DIVIDEND_W = 34,
  parameter int DIVISOR_W  = 21
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic      [DIVIDEND_W-1:0] quotient_o,
  output div_stat_t                  stat_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

endmodule

`default_nettype wire
